[rtl/core/led_pkg.sv]
// ----------------------------------------------------------------------------
// LED cipher package
// Shared types, constants and round functions for the LED block cipher.
// ----------------------------------------------------------------------------
package led_pkg;

  localparam int MAX_STEPS  = 12;
  localparam int MAX_ROUNDS = 4 * MAX_STEPS;
  localparam int STAGES     = MAX_ROUNDS + MAX_STEPS + 2;
  localparam int POS_W      = $clog2(STAGES);
  localparam int RND_W      = $clog2(MAX_ROUNDS);
  localparam int STEP_W     = $clog2(MAX_STEPS + 1);

  localparam logic [7:0] KEY_BITS_MIN = 8'd64;
  localparam logic [7:0] KEY_BITS_MAX = 8'd128;

  typedef enum logic [1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_KEY_BITS = 2'd2,
    REG_NUM_STEPS = 2'd3
  } reg_index_t;

  typedef logic [3:0] nib_t;
  typedef nib_t [15:0] state_t;

  // Per-item settings captured at entry.
  typedef struct packed {
    logic              dec;
    logic [7:0]        kb;
    logic [5:0]        count;
    logic [STEP_W-1:0] steps;
    logic [127:0]      key;
  } ctx_t;

  function automatic nib_t sbox_fwd(input nib_t x);
    case (x)
      4'h0: sbox_fwd = 4'd12; 4'h1: sbox_fwd = 4'd5;  4'h2: sbox_fwd = 4'd6;
      4'h3: sbox_fwd = 4'd11; 4'h4: sbox_fwd = 4'd9;  4'h5: sbox_fwd = 4'd0;
      4'h6: sbox_fwd = 4'd10; 4'h7: sbox_fwd = 4'd13; 4'h8: sbox_fwd = 4'd3;
      4'h9: sbox_fwd = 4'd14; 4'hA: sbox_fwd = 4'd15; 4'hB: sbox_fwd = 4'd8;
      4'hC: sbox_fwd = 4'd4;  4'hD: sbox_fwd = 4'd7;  4'hE: sbox_fwd = 4'd1;
      default: sbox_fwd = 4'd2;
    endcase
  endfunction

  function automatic nib_t sbox_inv(input nib_t x);
    case (x)
      4'h0: sbox_inv = 4'd5;  4'h1: sbox_inv = 4'd14; 4'h2: sbox_inv = 4'd15;
      4'h3: sbox_inv = 4'd8;  4'h4: sbox_inv = 4'd12; 4'h5: sbox_inv = 4'd1;
      4'h6: sbox_inv = 4'd2;  4'h7: sbox_inv = 4'd13; 4'h8: sbox_inv = 4'd11;
      4'h9: sbox_inv = 4'd4;  4'hA: sbox_inv = 4'd6;  4'hB: sbox_inv = 4'd3;
      4'hC: sbox_inv = 4'd0;  4'hD: sbox_inv = 4'd7;  4'hE: sbox_inv = 4'd9;
      default: sbox_inv = 4'd10;
    endcase
  endfunction

  function automatic logic [5:0] rcon(input logic [RND_W-1:0] r);
    logic [5:0] rc;
    rc = 6'h01;
    case (r)
      6'd0: rc = 6'h01;  6'd1: rc = 6'h03;  6'd2: rc = 6'h07;  6'd3: rc = 6'h0F;
      6'd4: rc = 6'h1F;  6'd5: rc = 6'h3E;  6'd6: rc = 6'h3D;  6'd7: rc = 6'h3B;
      6'd8: rc = 6'h37;  6'd9: rc = 6'h2F;  6'd10: rc = 6'h1E; 6'd11: rc = 6'h3C;
      6'd12: rc = 6'h39; 6'd13: rc = 6'h33; 6'd14: rc = 6'h27; 6'd15: rc = 6'h0E;
      6'd16: rc = 6'h1D; 6'd17: rc = 6'h3A; 6'd18: rc = 6'h35; 6'd19: rc = 6'h2B;
      6'd20: rc = 6'h16; 6'd21: rc = 6'h2C; 6'd22: rc = 6'h18; 6'd23: rc = 6'h30;
      6'd24: rc = 6'h21; 6'd25: rc = 6'h02; 6'd26: rc = 6'h05; 6'd27: rc = 6'h0B;
      6'd28: rc = 6'h17; 6'd29: rc = 6'h2E; 6'd30: rc = 6'h1C; 6'd31: rc = 6'h38;
      6'd32: rc = 6'h31; 6'd33: rc = 6'h23; 6'd34: rc = 6'h06; 6'd35: rc = 6'h0D;
      6'd36: rc = 6'h1B; 6'd37: rc = 6'h36; 6'd38: rc = 6'h2D; 6'd39: rc = 6'h1A;
      6'd40: rc = 6'h34; 6'd41: rc = 6'h29; 6'd42: rc = 6'h12; 6'd43: rc = 6'h24;
      6'd44: rc = 6'h08; 6'd45: rc = 6'h11; 6'd46: rc = 6'h22; 6'd47: rc = 6'h04;
      default: rc = 6'h00;
    endcase
    return rc;
  endfunction

  // GF(16) multiply with x^4+x+1.
  function automatic nib_t gmul(input nib_t a, input nib_t b);
    nib_t x, acc;
    x = a;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc ^= x;
      x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
    end
    return acc;
  endfunction

  function automatic nib_t mixf(input int i);
    case (i)
      0: mixf = 4'd4;  1: mixf = 4'd1;  2: mixf = 4'd2;  3: mixf = 4'd2;
      4: mixf = 4'd8;  5: mixf = 4'd6;  6: mixf = 4'd5;  7: mixf = 4'd6;
      8: mixf = 4'd11; 9: mixf = 4'd14; 10: mixf = 4'd10; 11: mixf = 4'd9;
      12: mixf = 4'd2; 13: mixf = 4'd2; 14: mixf = 4'd15; default: mixf = 4'd11;
    endcase
  endfunction

  function automatic nib_t mixi(input int i);
    case (i)
      0: mixi = 4'd12; 1: mixi = 4'd12; 2: mixi = 4'd13; 3: mixi = 4'd4;
      4: mixi = 4'd3;  5: mixi = 4'd8;  6: mixi = 4'd4;  7: mixi = 4'd5;
      8: mixi = 4'd7;  9: mixi = 4'd6;  10: mixi = 4'd2; 11: mixi = 4'd14;
      12: mixi = 4'd13; 13: mixi = 4'd9; 14: mixi = 4'd9; default: mixi = 4'd13;
    endcase
  endfunction

  function automatic state_t add_consts(input state_t s, input logic [7:0] kb,
                                        input logic [RND_W-1:0] r);
    state_t o;
    logic [5:0] rc;
    o = s;
    rc = rcon(r);
    o[15-0]  ^= kb[7:4];
    o[15-4]  ^= 4'h1 ^ kb[7:4];
    o[15-8]  ^= 4'h2 ^ kb[3:0];
    o[15-12] ^= 4'h3 ^ kb[3:0];
    o[15-1]  ^= {1'b0, rc[5:3]};
    o[15-9]  ^= {1'b0, rc[5:3]};
    o[15-5]  ^= {1'b0, rc[2:0]};
    o[15-13] ^= {1'b0, rc[2:0]};
    return o;
  endfunction

  function automatic state_t round_fwd(input state_t s);
    state_t a, b, o;
    for (int c = 0; c < 16; c++) a[15-c] = sbox_fwd(s[15-c]);
    for (int r = 0; r < 4; r++)
      for (int j = 0; j < 4; j++) b[15-(4*r+j)] = a[15-(4*r+((j+r)%4))];
    for (int j = 0; j < 4; j++)
      for (int i = 0; i < 4; i++) begin
        o[15-(4*i+j)] = '0;
        for (int k = 0; k < 4; k++) o[15-(4*i+j)] ^= gmul(mixf(4*i+k), b[15-(4*k+j)]);
      end
    return o;
  endfunction

  function automatic state_t round_inv(input state_t s);
    state_t a, b, o;
    for (int j = 0; j < 4; j++)
      for (int i = 0; i < 4; i++) begin
        a[15-(4*i+j)] = '0;
        for (int k = 0; k < 4; k++) a[15-(4*i+j)] ^= gmul(mixi(4*i+k), s[15-(4*k+j)]);
      end
    for (int r = 0; r < 4; r++)
      for (int j = 0; j < 4; j++) b[15-(4*r+((j+r)%4))] = a[15-(4*r+j)];
    for (int c = 0; c < 16; c++) o[15-c] = sbox_inv(b[15-c]);
    return o;
  endfunction

  // Key addition number st: cell c takes nibble (c + 16*st) mod count.
  // The start index 16*st mod count comes from four compare-and-subtract
  // steps; the quotient stays below 16 because count is at least 16.
  function automatic state_t add_key(input state_t s, input logic [127:0] key,
                                     input logic [5:0] count,
                                     input logic [STEP_W-1:0] st);
    state_t o;
    logic [8:0] v;
    logic [5:0] base, idx;
    logic [6:0] t;
    v = 9'({st, 4'b0000});
    for (int b = 3; b >= 0; b--) begin
      if (v >= (9'(count) << b)) v = v - (9'(count) << b);
    end
    base = v[5:0];
    for (int c = 0; c < 16; c++) begin
      t = {1'b0, base} + 7'(c);
      if (t >= {1'b0, count}) t = t - {1'b0, count};
      idx = t[5:0];
      o[15-c] = s[15-c] ^ key[127-4*idx[4:0] -: 4];
    end
    return o;
  endfunction

endpackage

[rtl/core/led_stream_if.sv]
// ----------------------------------------------------------------------------
// LED stream interface
// Valid/ready channel carrying a payload of a given type.
// ----------------------------------------------------------------------------
interface led_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/led_stage.sv]
// ----------------------------------------------------------------------------
// LED pipeline stage
// One registered stage: a round (forward or inverse) or a key addition,
// selected per item from the stage position and the item's step count.
// ----------------------------------------------------------------------------
module led_stage import led_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [POS_W-1:0]              pos,
  input  logic [STEP_W-1:0]             step_idx,
  input  logic [2:0]                    sub,
  input  logic                          valid_in,
  input  ctx_t                          ctx_in,
  input  state_t                        st_in,
  output logic                          valid,
  output ctx_t                          ctx,
  output state_t                        st
);

  // Stage layout: pos 0 initial key, then per step four rounds and a key add.
  // Stages past the item's step count pass data through.
  logic [RND_W-1:0]  rnd;
  logic [STEP_W-1:0] kn;
  state_t            st_next;

  always_comb begin
    st_next  = st_in;
    rnd      = '0;
    if (pos == '0) begin
      kn = ctx_in.dec ? ctx_in.steps : '0;
      st_next = add_key(st_in, ctx_in.key, ctx_in.count, kn);
    end else begin
      kn = ctx_in.dec ? STEP_W'(ctx_in.steps - step_idx - 1'b1) : STEP_W'(step_idx + 1'b1);
      if (step_idx < ctx_in.steps) begin
        if (sub == 3'd4) begin
          st_next = add_key(st_in, ctx_in.key, ctx_in.count, kn);
        end else if (ctx_in.dec) begin
          rnd = RND_W'(4 * (32'(ctx_in.steps) - 32'(step_idx) - 1) + 3 - 32'(sub));
          st_next = add_consts(round_inv(st_in), ctx_in.kb, rnd);
        end else begin
          rnd = RND_W'(4 * 32'(step_idx) + 32'(sub));
          st_next = round_fwd(add_consts(st_in, ctx_in.kb, rnd));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      ctx <= ctx_in;
      st  <= st_next;
    end
  end

endmodule

[rtl/core/led_block_cipher.sv]
// ----------------------------------------------------------------------------
// LED block cipher, unrolled pipeline
// Throughput: one block per cycle; the pipeline advances whenever its last
// register is empty or being taken, so an output stall backs up the chain.
// Reset (rst, synchronous) clears all stage valid bits and the registers to
// key 0, key_bits 64, num_steps 1.
// ----------------------------------------------------------------------------
module led_block_cipher import led_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  led_stream_if.sink   in_ch,
  led_stream_if.source out_ch
);

  // Configuration registers.
  logic [63:0] key_high, key_low;
  logic [7:0]  key_bits;
  logic [3:0]  num_steps;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high  <= '0;
      key_low   <= '0;
      key_bits  <= KEY_BITS_MIN;
      num_steps <= 4'd1;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_KEY_HIGH:  key_high  <= cfg_data;
        REG_KEY_LOW:   key_low   <= cfg_data;
        REG_KEY_BITS:  key_bits  <= cfg_data[7:0];
        REG_NUM_STEPS: num_steps <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Clamp the settings once at entry; every stage then sees the item's copy.
  ctx_t ctx0;
  always_comb begin
    ctx0.dec = in_ch.data[64];
    if (key_bits < KEY_BITS_MIN)      ctx0.kb = KEY_BITS_MIN;
    else if (key_bits > KEY_BITS_MAX) ctx0.kb = KEY_BITS_MAX;
    else                              ctx0.kb = key_bits;
    ctx0.count = ctx0.kb[7:2];
    if (num_steps == 4'd0)               ctx0.steps = STEP_W'(1);
    else if (32'(num_steps) > MAX_STEPS) ctx0.steps = STEP_W'(MAX_STEPS);
    else                                 ctx0.steps = STEP_W'(num_steps);
    ctx0.key = {key_high, key_low};
  end

  // The whole chain moves together; it advances when the last stage frees.
  logic en;
  logic   v   [STAGES+1];
  ctx_t   cx  [STAGES+1];
  state_t sv  [STAGES+1];

  assign v[0]  = in_ch.valid;
  assign cx[0] = ctx0;
  assign sv[0] = in_ch.data[63:0];
  assign en    = !v[STAGES] || out_ch.ready;
  assign in_ch.ready = en;

  // Each stage's step number and slot within the step are fixed by its place.
  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    led_stage u_stage (
      .clk, .rst, .en,
      .pos      (POS_W'(g)),
      .step_idx (STEP_W'(g == 0 ? 0 : (g - 1) / 5)),
      .sub      (3'(g == 0 ? 0 : (g - 1) % 5)),
      .valid_in (v[g]),
      .ctx_in   (cx[g]),
      .st_in    (sv[g]),
      .valid    (v[g+1]),
      .ctx      (cx[g+1]),
      .st       (sv[g+1])
    );
  end

  assign out_ch.valid = v[STAGES];
  assign out_ch.data  = sv[STAGES];

  // A held result must not change while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed during stall");
  // Input is taken exactly when the chain moves.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("ready does not follow chain enable");

endmodule

[verif/led_block_cipher_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED block cipher testbench
// Streams encrypt and decrypt requests through the cipher under several key
// sizes and step counts, predicts every output block with an independent
// model of the rounds, and compares results in order under random flow control.
// ----------------------------------------------------------------------------
module led_block_cipher_tb;
  import led_pkg::*;

  typedef struct packed {
    logic        func;
    logic [63:0] block_in;
  } cipher_req_t;

  typedef struct packed {
    logic [63:0] block_out;
  } cipher_rsp_t;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;
  localparam int   STALL_LIMIT = 20000;

  // Scoreboard: keeps the expected output blocks in acceptance order.
  class block_scoreboard;
    logic [63:0] pending_blocks[$];
    int          mismatches = 0;

    function void note_request(logic [63:0] predicted);
      pending_blocks.push_back(predicted);
    endfunction

    function void check_result(logic [63:0] observed);
      logic [63:0] predicted;
      if (pending_blocks.size() == 0) begin
        $error("block_out: expected nothing, actual %h", observed);
        mismatches++;
      end else begin
        predicted = pending_blocks.pop_front();
        if (predicted !== observed) begin
          $error("block_out: expected %h, actual %h", predicted, observed);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  led_stream_if #(.payload_t(cipher_req_t)) in_ch ();
  led_stream_if #(.payload_t(cipher_rsp_t)) out_ch ();

  led_block_cipher DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  block_scoreboard sb = new();

  // Shadow copy of the cipher settings, updated on every register write.
  logic [63:0] key_hi_shadow  = '0;
  logic [63:0] key_lo_shadow  = '0;
  logic [7:0]  key_bits_shadow = 8'd64;
  logic [3:0]  steps_shadow   = 4'd1;

  // Flow control knobs for the driver and the receiver.
  bit no_idle     = 0;
  bit rx_hold     = 0;
  int idle_cycles = 0;
  bit timed_out   = 0;

  // S-boxes and mixing matrices of the cipher, row-major.
  localparam logic [3:0] SBOX[16]  = '{12, 5, 6, 11, 9, 0, 10, 13, 3, 14, 15, 8, 4, 7, 1, 2};
  localparam logic [3:0] ISBOX[16] = '{5, 14, 15, 8, 12, 1, 2, 13, 11, 4, 6, 3, 0, 7, 9, 10};
  localparam logic [3:0] MIXF[16]  = '{4, 1, 2, 2, 8, 6, 5, 6, 11, 14, 10, 9, 2, 2, 15, 11};
  localparam logic [3:0] MIXI[16]  = '{12, 12, 13, 4, 3, 8, 4, 5, 7, 6, 2, 14, 13, 9, 9, 13};

  function automatic logic [3:0] gf16_times(logic [3:0] a, logic [3:0] b);
    logic [3:0] x, acc;
    x = a;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc ^= x;
      x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
    end
    return acc;
  endfunction

  // The round constant sequence is a 6-bit LFSR starting at 0x01.
  function automatic logic [5:0] round_constant(int r);
    logic [5:0] rc;
    rc = 6'h01;
    for (int i = 0; i < r; i++) rc = {rc[4:0], rc[5] ^ rc[4] ^ 1'b1};
    return rc;
  endfunction

  // Computes the output block for one request under the shadow settings.
  function automatic logic [63:0] led_transform(logic dec, logic [63:0] blk);
    logic [3:0]   s[16], t[16], keyn[32];
    logic [127:0] key;
    logic [7:0]   kb;
    logic [5:0]   rc;
    int           nsteps, nkey, rnd, ks;
    logic [63:0]  res;
    kb = key_bits_shadow;
    if (kb < 8'd64) kb = 8'd64;
    if (kb > 8'd128) kb = 8'd128;
    nkey = kb >> 2;
    nsteps = steps_shadow;
    if (nsteps < 1) nsteps = 1;
    if (nsteps > MAX_STEPS) nsteps = MAX_STEPS;
    key = {key_hi_shadow, key_lo_shadow};
    for (int c = 0; c < 32; c++) keyn[c] = key[127 - 4 * c -: 4];
    for (int c = 0; c < 16; c++) s[c] = blk[63 - 4 * c -: 4];

    // Key additions are numbered 0..nsteps; decryption walks them backward.
    ks = dec ? nsteps : 0;
    for (int c = 0; c < 16; c++) s[c] ^= keyn[(c + 16 * ks) % nkey];
    for (int st = 0; st < nsteps; st++) begin
      for (int j = 0; j < 4; j++) begin
        rnd = dec ? 4 * (nsteps - 1 - st) + (3 - j) : 4 * st + j;
        rc = round_constant(rnd);
        if (!dec) begin
          s[0] ^= kb[7:4];         s[4] ^= 4'h1 ^ kb[7:4];
          s[8] ^= 4'h2 ^ kb[3:0];  s[12] ^= 4'h3 ^ kb[3:0];
          s[1] ^= {1'b0, rc[5:3]}; s[9] ^= {1'b0, rc[5:3]};
          s[5] ^= {1'b0, rc[2:0]}; s[13] ^= {1'b0, rc[2:0]};
          for (int c = 0; c < 16; c++) t[c] = SBOX[s[c]];
          for (int r = 0; r < 4; r++)
            for (int k = 0; k < 4; k++) s[4 * r + k] = t[4 * r + ((k + r) % 4)];
          for (int k = 0; k < 4; k++)
            for (int i = 0; i < 4; i++) begin
              t[4 * i + k] = '0;
              for (int m = 0; m < 4; m++)
                t[4 * i + k] ^= gf16_times(MIXF[4 * i + m], s[4 * m + k]);
            end
          s = t;
        end else begin
          for (int k = 0; k < 4; k++)
            for (int i = 0; i < 4; i++) begin
              t[4 * i + k] = '0;
              for (int m = 0; m < 4; m++)
                t[4 * i + k] ^= gf16_times(MIXI[4 * i + m], s[4 * m + k]);
            end
          for (int r = 0; r < 4; r++)
            for (int k = 0; k < 4; k++) s[4 * r + ((k + r) % 4)] = t[4 * r + k];
          for (int c = 0; c < 16; c++) s[c] = ISBOX[s[c]];
          s[0] ^= kb[7:4];         s[4] ^= 4'h1 ^ kb[7:4];
          s[8] ^= 4'h2 ^ kb[3:0];  s[12] ^= 4'h3 ^ kb[3:0];
          s[1] ^= {1'b0, rc[5:3]}; s[9] ^= {1'b0, rc[5:3]};
          s[5] ^= {1'b0, rc[2:0]}; s[13] ^= {1'b0, rc[2:0]};
        end
      end
      ks = dec ? nsteps - 1 - st : st + 1;
      for (int c = 0; c < 16; c++) s[c] ^= keyn[(c + 16 * ks) % nkey];
    end
    for (int c = 0; c < 16; c++) res[63 - 4 * c -: 4] = s[c];
    return res;
  endfunction

  // Receiver: random backpressure, plus a long hold when rx_hold is set.
  // It also checks every accepted result and runs the stall watchdog.
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data.block_out);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else if (sb.pending_blocks.size() != 0 || in_ch.valid)
        idle_cycles <= idle_cycles + 1;
      out_ch.ready <= !rx_hold && (no_idle || $urandom_range(99) >= 19);
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("led_block_cipher_tb NOT OK");
      $finish;
    end
  end

  // Writes one register and mirrors it in the shadow copy.
  task automatic write_reg(reg_index_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_KEY_HIGH:  key_hi_shadow = value;
      REG_KEY_LOW:   key_lo_shadow = value;
      REG_KEY_BITS:  key_bits_shadow = value[7:0];
      default:       steps_shadow = value[3:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offers one request and returns once it has been accepted. Random idle
  // cycles come first, so valid only drops when a gap is actually taken.
  task automatic send_block(logic func, logic [63:0] blk);
    cipher_req_t req;
    req.func = func;
    req.block_in = blk;
    while (!no_idle && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= req;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(led_transform(func, blk));
  endtask

  // Lets the pipeline empty before the settings change.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_blocks.size() != 0) @(posedge clk);
    repeat (STAGES + 8) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_blocks(int n);
    logic [63:0] blk;
    for (int i = 0; i < n; i++) begin
      // Mostly random data, with some sparse and dense patterns mixed in.
      case ($urandom_range(5))
        0:       blk = 64'd1 << $urandom_range(63);
        1:       blk = ~(64'd1 << $urandom_range(63));
        default: blk = rand64();
      endcase
      send_block(1'($urandom_range(1)), blk);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings: 64-bit zero key, one step.
    send_block(OP_ENCRYPT, 64'h0);
    send_block(OP_DECRYPT, 64'h0);
    send_block(OP_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(OP_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);
    send_block(OP_DECRYPT, 64'hFEDC_BA98_7654_3210);
    drain();

    // Full 128-bit key, maximum steps, extreme key values.
    write_reg(REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_KEY_LOW, 64'h0);
    write_reg(REG_KEY_BITS, 64'd128);
    write_reg(REG_NUM_STEPS, 64'd12);
    send_block(OP_ENCRYPT, 64'h0);
    send_block(OP_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(OP_ENCRYPT, 64'h8000_0000_0000_0001);
    drain();

    // Out-of-range settings: key size below and above range, odd size,
    // a step count of zero and one above the maximum.
    write_reg(REG_KEY_BITS, 64'd0);
    write_reg(REG_NUM_STEPS, 64'd0);
    send_block(OP_ENCRYPT, 64'h1111_2222_3333_4444);
    send_block(OP_DECRYPT, 64'h1111_2222_3333_4444);
    drain();
    write_reg(REG_KEY_BITS, 64'hFF);
    write_reg(REG_NUM_STEPS, 64'd15);
    send_block(OP_ENCRYPT, 64'hA5A5_5A5A_A5A5_5A5A);
    send_block(OP_DECRYPT, 64'hA5A5_5A5A_A5A5_5A5A);
    drain();
    write_reg(REG_KEY_BITS, 64'd67);
    write_reg(REG_NUM_STEPS, 64'd13);
    send_block(OP_ENCRYPT, 64'hDEAD_BEEF_CAFE_F00D);
    send_block(OP_DECRYPT, 64'hDEAD_BEEF_CAFE_F00D);
    drain();

    // Random phases, each with its own key, size and step count.
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_KEY_HIGH, rand64());
      write_reg(REG_KEY_LOW, rand64());
      case (phase)
        0:       write_reg(REG_KEY_BITS, 64'd64);
        1:       write_reg(REG_KEY_BITS, 64'd128);
        2:       write_reg(REG_KEY_BITS, 64'd100);
        3:       write_reg(REG_KEY_BITS, 64'd81);
        default: write_reg(REG_KEY_BITS, 64'($urandom_range(255)));
      endcase
      // Phases 1 and 5 use the maximum step count; the others use a random one.
      if (phase == 1 || phase == 5) write_reg(REG_NUM_STEPS, 64'd12);
      else write_reg(REG_NUM_STEPS, 64'($urandom_range(15)));

      if (phase == 2) begin
        // A long receiver hold with the sender still offering fills the
        // pipeline and must stall the input side.
        fork
          begin
            rx_hold = 1;
            repeat (300) @(posedge clk);
            rx_hold = 0;
          end
        join_none
      end
      no_idle = (phase == 4);
      random_blocks(220);
      no_idle = 0;
      drain();
    end

    if (sb.mismatches == 0 && !timed_out) begin
      $display("led_block_cipher_tb OK");
    end else begin
      $display("led_block_cipher_tb NOT OK");
    end
    $finish;
  end

endmodule
